@@ rtl/core/pfe_pkg.sv @@
package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // Operator characters and the digit offset
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'd48;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_e;

  typedef struct packed {
    logic done;
    logic div_zero;
  } div_stat_t;

endpackage

@@ rtl/core/pfe_div.sv @@
module pfe_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pfe_pkg::VALUE_WIDTH-1:0]     dividend_i,
  input  logic [pfe_pkg::VALUE_WIDTH-1:0]     divisor_i,
  output logic [pfe_pkg::VALUE_WIDTH-1:0]     quotient_o,
  output pfe_pkg::div_stat_t                  stat_o
);

  localparam int VW = pfe_pkg::VALUE_WIDTH;
  localparam int CW = $clog2(VW);

  logic          busy_q;
  logic          done_q;
  logic          dz_q;
  logic          neg_q;
  logic [CW-1:0] step_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] quot_q;
  logic [VW-1:0] dsr_q;

  logic          na;
  logic          nb;
  logic [VW-1:0] ma;
  logic [VW-1:0] mb;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign na     = dividend_i[VW-1];
  assign nb     = divisor_i[VW-1];
  assign ma     = na ? (VW'(0) - dividend_i) : dividend_i;
  assign mb     = nb ? (VW'(0) - divisor_i) : divisor_i;
  assign rem_sh = {rem_q, quot_q[VW-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = !diff[VW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dz_q   <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dz_q   <= (mb == '0);
        step_q <= '0;
        if (mb == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        step_q <= step_q + CW'(1);
        if (step_q == CW'(VW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, restoring on the magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quot_q <= ma;
      dsr_q  <= mb;
      neg_q  <= na ^ nb;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      quot_q <= {quot_q[VW-2:0], ge};
    end
  end

  assign quotient_o      = neg_q ? (VW'(0) - quot_q) : quot_q;
  assign stat_o.done     = done_q;
  assign stat_o.div_zero = dz_q;

endmodule

@@ rtl/core/postfix_expression_evaluator_top.sv @@
// Postfix expression evaluator.
// Input channel: one expression character per transaction on token_char_i,
// with last_char_i set on the final character. Operators + - * / pop the
// right then the left operand and push left op right; any other character
// pushes its code minus 48. Values wrap at VALUE_WIDTH bits.
// Output channel: one transaction per expression, after the last character:
// the popped top value (sign-extended) and the first error of the
// expression (0 ok, 1 underflow, 2 overflow, 3 divide by zero).
// Each character is stepped by the sequencer around the one-read-port stack
// memory: a digit is pushed; an operator pops both operands, computes and
// pushes; a divide waits on the bit-serial divider, which ends early when
// the divisor is zero. A last character then pops the result for output.
// in_stall_o is high while a character is in progress. A result waits in
// the output register while out_stall_i is high; the next expression runs
// meanwhile and holds only at its own result until the register frees.
// Reset empties the stack and clears the error; stack contents need no
// clearing pass. Values left on the stack carry over to the next expression.
module postfix_expression_evaluator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          token_char_i,
  input  logic                last_char_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_value_o,
  output logic [1:0]          error_code_o
);

  localparam int VW    = pfe_pkg::VALUE_WIDTH;
  localparam int AW    = pfe_pkg::ADDR_W;
  localparam int CW    = pfe_pkg::CNT_W;
  localparam int DEPTH = pfe_pkg::STACK_DEPTH;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POPR = 8'b0000_0010,
    S_POPL = 8'b0000_0100,
    S_CALC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_PUSH = 8'b0010_0000,
    S_POPE = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  pfe_pkg::err_e      err_q, err_d;
  logic [7:0]         ch_q, ch_d;
  logic               last_q, last_d;
  logic [VW-1:0]      opr_q, opr_d;
  logic [VW-1:0]      val_q, val_d;
  logic               rd_ok_q, rd_ok_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] res_q, res_d;
  pfe_pkg::err_e      oerr_q, oerr_d;

  logic [VW-1:0]      mem [DEPTH];
  logic [VW-1:0]      rdata_q;
  logic               rd_en;
  logic               wr_en;
  logic [CW-1:0]      cnt_dec;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;

  logic               pop_req;
  pfe_pkg::err_e      note;
  logic [VW-1:0]      popped;
  logic               is_op;

  logic               div_start;
  logic [VW-1:0]      div_quot;
  pfe_pkg::div_stat_t div_stat;

  assign cnt_dec = count_q - CW'(1);
  assign rd_addr = cnt_dec[AW-1:0];
  assign wr_addr = count_q[AW-1:0];
  assign popped  = rd_ok_q ? rdata_q : '0;
  assign is_op   = (token_char_i == pfe_pkg::CH_ADD) || (token_char_i == pfe_pkg::CH_SUB) ||
                   (token_char_i == pfe_pkg::CH_MUL) || (token_char_i == pfe_pkg::CH_DIV);

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (popped),
    .divisor_i  (opr_q),
    .quotient_o (div_quot),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    ch_d        = ch_q;
    last_d      = last_q;
    opr_d       = opr_q;
    val_d       = val_q;
    rd_ok_d     = rd_ok_q;
    res_d       = res_q;
    oerr_d      = oerr_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    pop_req     = 1'b0;
    div_start   = 1'b0;
    note        = pfe_pkg::ERR_NONE;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d    = token_char_i;
          last_d  = last_char_i;
          val_d   = VW'(token_char_i) - VW'(pfe_pkg::CH_ZERO);
          state_d = is_op ? S_POPR : S_PUSH;
        end
      end
      S_POPR: begin
        pop_req = 1'b1;
        state_d = S_POPL;
      end
      S_POPL: begin
        opr_d   = popped;
        pop_req = 1'b1;
        state_d = S_CALC;
      end
      S_CALC: begin
        state_d = S_PUSH;
        case (ch_q)
          pfe_pkg::CH_ADD: val_d = popped + opr_q;
          pfe_pkg::CH_SUB: val_d = popped - opr_q;
          pfe_pkg::CH_MUL: val_d = popped * opr_q;
          pfe_pkg::CH_DIV: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          default: val_d = val_q;
        endcase
      end
      S_DIV: begin
        if (div_stat.done) begin
          val_d   = div_stat.div_zero ? '0 : div_quot;
          note    = div_stat.div_zero ? pfe_pkg::ERR_DIV0 : pfe_pkg::ERR_NONE;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count_q == CW'(DEPTH)) begin
          note = pfe_pkg::ERR_OVER;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
        state_d = last_q ? S_POPE : S_IDLE;
      end
      S_POPE: begin
        pop_req = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_d       = 32'(signed'(popped));
          oerr_d      = err_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (pop_req) begin
      if (count_q != '0) begin
        rd_en   = 1'b1;
        rd_ok_d = 1'b1;
        count_d = cnt_dec;
      end else begin
        rd_ok_d = 1'b0;
        note    = pfe_pkg::ERR_UNDER;
      end
    end

    if (err_q == pfe_pkg::ERR_NONE) begin
      err_d = note;
    end
    if (state_q == S_EMIT && (!out_valid_q || !out_stall_i)) begin
      err_d = pfe_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= pfe_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      rd_ok_q     <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
    opr_q  <= opr_d;
    val_q  <= val_d;
    res_q  <= res_d;
    oerr_q <= oerr_d;
  end

  // Stack memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign error_code_o   = oerr_q;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("stack count beyond depth");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> count_q < CW'(DEPTH))
    else $error("push onto full stack reached memory");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("stack read and write in the same cycle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != S_IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_emit_clears_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || !out_stall_i))
      |=> out_valid_q && err_q == pfe_pkg::ERR_NONE && state_q == S_IDLE)
    else $error("result load did not clear the expression error");
`endif

endmodule
